[design/dmc_pkg.sv]
// Shared types, constants and helper functions of the direct-mapped cache lookup unit.
package dmc_pkg;

   localparam int SET_COUNT   = 16;
   localparam int SET_W       = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
   localparam int MAX_DUMP    = 16;
   localparam int DUMP_COUNT  = (SET_COUNT < MAX_DUMP) ? SET_COUNT : MAX_DUMP;
   localparam int ADDR_W      = 32;
   localparam int TAG_W       = 26;
   localparam int WORD_W      = 32;
   localparam int BYTE_W      = 8;
   localparam int OFF_W       = 2;
   localparam int SET_FIELD_W = 4;
   localparam int TAG_LSB     = 6;
   localparam int SET_LSB     = 2;
   localparam int FUNC_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 72;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_READ  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_DUMP  = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_RD_INVALID = 3'd0,
      STS_RD_MISS    = 3'd1,
      STS_RD_HIT     = 3'd2,
      STS_WR_CLEAN   = 3'd3,
      STS_WR_EVICT   = 3'd4,
      STS_DUMP       = 3'd5
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic              re;
      logic [SET_W-1:0]  raddr;
      logic              we;
      logic [SET_W-1:0]  waddr;
      logic [TAG_W-1:0]  wtag;
      logic [WORD_W-1:0] wword;
   } store_req_type;

   typedef struct packed {
      logic              valid;
      logic [TAG_W-1:0]  tag;
      logic [WORD_W-1:0] word;
   } store_rsp_type;

   localparam logic [SET_W-1:0] DUMP_LAST = SET_W'(DUMP_COUNT - 1);

   function automatic logic [SET_W-1:0] reduce_set(input logic [SET_FIELD_W-1:0] field);
      logic [SET_FIELD_W-1:0]       v;
      logic [SET_W+SET_FIELD_W-1:0] t;
      v = field;
      for (int i = 0; i < 8; i++) begin
         if (int'(v) >= SET_COUNT) begin
            v = v - SET_FIELD_W'(SET_COUNT);
         end
      end
      t = {SET_W'(0), v};
      return t[SET_W-1:0];
   endfunction

   function automatic logic [SET_FIELD_W-1:0] set_field(input logic [SET_W-1:0] idx);
      logic [SET_W+SET_FIELD_W-1:0] t;
      t = {SET_FIELD_W'(0), idx};
      return t[SET_FIELD_W-1:0];
   endfunction

endpackage

[design/direct_mapped_cache_lookup_unit.sv]
// Top level of the direct-mapped cache lookup unit.
//
//  Channel  Direction  Handshake              Contents
//  req      in         req_tvalid/req_tready  tuser: operation; tdata: address, write word
//  rsp      out        rsp_tvalid/rsp_tready  tuser: status; tdata: line report; tlast
//
// A read or write request is taken as its line is read into the store's read register;
// its response is then registered in the output register. Requests flow at one per
// cycle while responses are taken, at the pace of the registered line memory read.
// A dump gives one line per cycle while responses are taken, one for each stored line;
// an unused operation code waits for no output space and gives no response.
// Reset clears the valid bits at once; there is no clearing pass.
// While a response waits in the output register, the request in hand waits with it.
module direct_mapped_cache_lookup_unit
   import dmc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // address [31:0], write_data [63:32]
   input  logic [FUNC_W-1:0]     req_tuser,  // func [1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // line_set [3:0], line_tag [29:4],
                                             // line_word [61:30], line_valid [62],
                                             // byte_out [70:63], zero [71]
   output logic [STATUS_W-1:0]   rsp_tuser,  // status [2:0]
   output logic                  rsp_tlast   // last
);

   store_req_type st_req;
   store_rsp_type st_rsp;

   dmc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .st_req     (st_req),
      .st_rsp     (st_rsp)
   );

   dmc_store u_store (
      .clock  (clock),
      .reset  (reset),
      .st_req (st_req),
      .st_rsp (st_rsp)
   );

endmodule

[design/dmc_store.sv]
// Line store: tag and word memory with a registered read port, plus the valid bits.
module dmc_store
   import dmc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  store_req_type st_req,
   output store_rsp_type st_rsp
);

   logic [TAG_W+WORD_W-1:0] lines_ff [SET_COUNT];
   logic [SET_COUNT-1:0]    valid_ff;
   logic [SET_COUNT-1:0]    valid_in;
   logic [TAG_W+WORD_W-1:0] rd_line_ff;
   logic                    rd_valid_ff;
   logic                    fwd;

   assign fwd = st_req.we && (st_req.waddr == st_req.raddr);

   always_comb begin
      valid_in = valid_ff;
      if (st_req.we) begin
         valid_in[st_req.waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (st_req.re) begin
            rd_valid_ff <= valid_ff[st_req.raddr] || fwd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (st_req.we) begin
         lines_ff[st_req.waddr] <= {st_req.wtag, st_req.wword};
      end
      if (st_req.re) begin
         rd_line_ff <= fwd ? {st_req.wtag, st_req.wword} : lines_ff[st_req.raddr];
      end
   end

   // A line that was never written reads as its cleared value.
   assign st_rsp.valid = rd_valid_ff;
   assign st_rsp.tag   = rd_valid_ff ? rd_line_ff[TAG_W+WORD_W-1:WORD_W] : '0;
   assign st_rsp.word  = rd_valid_ff ? rd_line_ff[WORD_W-1:0] : '0;

endmodule

[design/dmc_seq.sv]
// Request sequencer: lookup and dump control, result formation and the output register.
module dmc_seq
   import dmc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [FUNC_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]   rsp_tuser,
   output logic                  rsp_tlast,
   output store_req_type         st_req,
   input  store_rsp_type         st_rsp
);

   state_type                state_ff, state_in;
   func_type                 func_ff, in_func;
   logic [SET_W-1:0]         set_ff, in_set;
   logic [TAG_W-1:0]         tag_ff;
   logic [OFF_W-1:0]         off_ff;
   logic [WORD_W-1:0]        data_ff;
   logic [SET_W-1:0]         cnt_ff, cnt_in;
   logic [ADDR_W-1:0]        in_addr;

   logic                     out_free, adv, finish, accept, emit;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, res_status;
   logic [SET_FIELD_W-1:0]   rsp_set_ff, res_set;
   logic [TAG_W-1:0]         rsp_tag_ff, res_tag;
   logic [WORD_W-1:0]        rsp_word_ff, res_word;
   logic                     rsp_lvalid_ff, res_lvalid;
   logic [BYTE_W-1:0]        rsp_byte_ff, res_byte;
   logic                     rsp_last_ff, res_last;

   assign in_func = func_type'(req_tuser);
   assign in_addr = req_tdata[ADDR_W-1:0];
   assign in_set  = reduce_set(in_addr[SET_LSB+SET_FIELD_W-1:SET_LSB]);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign adv        = (state_ff == ST_RESP) && (out_free || (func_ff == FUNC_NOP));
   assign finish     = adv && ((func_ff != FUNC_DUMP) || (cnt_ff == DUMP_LAST));
   assign req_tready = !reset && ((state_ff == ST_IDLE) || finish);
   assign accept     = req_tvalid && req_tready;
   assign emit       = adv && (func_ff != FUNC_NOP);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (finish && !accept) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      st_req.re    = accept || (adv && (func_ff == FUNC_DUMP) && !finish);
      st_req.raddr = accept ? ((in_func == FUNC_DUMP) ? '0 : in_set) : cnt_ff + 1'b1;
      st_req.we    = adv && (func_ff == FUNC_WRITE);
      st_req.waddr = set_ff;
      st_req.wtag  = tag_ff;
      st_req.wword = data_ff;
   end

   assign cnt_in = accept ? '0 : ((adv && (func_ff == FUNC_DUMP)) ? cnt_ff + 1'b1 : cnt_ff);

   always_comb begin
      res_status = STS_DUMP;
      res_set    = set_field(set_ff);
      res_tag    = st_rsp.tag;
      res_word   = '0;
      res_lvalid = st_rsp.valid;
      res_byte   = '0;
      res_last   = 1'b1;
      unique case (func_ff)
         FUNC_READ: begin
            if (!st_rsp.valid) begin
               res_status = STS_RD_INVALID;
            end else begin
               res_status = (st_rsp.tag == tag_ff) ? STS_RD_HIT : STS_RD_MISS;
               res_byte   = st_rsp.word[{off_ff, 3'b000} +: BYTE_W];
            end
         end
         FUNC_WRITE: begin
            res_status = st_rsp.valid ? STS_WR_EVICT : STS_WR_CLEAN;
            res_word   = st_rsp.word;
         end
         FUNC_DUMP: begin
            res_status = STS_DUMP;
            res_set    = set_field(cnt_ff);
            res_word   = st_rsp.word;
            res_last   = (cnt_ff == DUMP_LAST);
         end
         FUNC_NOP: begin
            res_status = STS_DUMP;
         end
         default: res_status = STS_DUMP;
      endcase
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         func_ff      <= FUNC_NOP;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         if (accept) begin
            func_ff <= in_func;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         set_ff  <= in_set;
         tag_ff  <= in_addr[ADDR_W-1:TAG_LSB];
         off_ff  <= in_addr[OFF_W-1:0];
         data_ff <= req_tdata[REQ_DATA_W-1:ADDR_W];
      end
      if (emit) begin
         rsp_status_ff <= res_status;
         rsp_set_ff    <= res_set;
         rsp_tag_ff    <= res_tag;
         rsp_word_ff   <= res_word;
         rsp_lvalid_ff <= res_lvalid;
         rsp_byte_ff   <= res_byte;
         rsp_last_ff   <= res_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {1'b0, rsp_byte_ff, rsp_lvalid_ff, rsp_word_ff, rsp_tag_ff, rsp_set_ff};

endmodule

[design/dmc_checker.sv]
// Port-level checks of the direct-mapped cache lookup unit and their binding.
module dmc_checker
   import dmc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]   rsp_tuser,
   input logic                  rsp_tlast
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid straight after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("stalled response changed");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STS_DUMP) |-> rsp_tlast)
      else $error("read or write response without last");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser == STS_WR_CLEAN) || (rsp_tuser == STS_WR_EVICT)
         || (rsp_tuser == STS_DUMP) || (rsp_tuser == STS_RD_INVALID))
      |-> (rsp_tdata[70:63] == '0))
      else $error("byte reported where none is read");

   a_clean_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STS_WR_CLEAN) |-> (rsp_tdata[62:4] == '0))
      else $error("clean write reports line contents");

endmodule

bind direct_mapped_cache_lookup_unit dmc_checker u_dmc_checker (.*);
